@@ src/cpal_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpal_pkg
// Types and constants shared by the cumulative path arc length block.
// ----------------------------------------------------------------------------
package cpal_pkg;

   localparam int COORD_W   = 24;
   localparam int SUM_W     = 60;
   localparam int LEN_W     = 48;
   localparam int ROOT_W    = SUM_W / 2;
   localparam int REM_W     = ROOT_W + 2;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int STEP_W    = $clog2(ROOT_STEPS);

   typedef struct packed {
      logic signed [COORD_W-1:0] coord;
      logic                      first_image;
      logic                      last_of_image;
   } cpal_req_type;

   typedef struct packed {
      logic [LEN_W-1:0] arc_length;
      logic             saturated;
   } cpal_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_ACCUM,
      ST_ROOT,
      ST_LENGTH,
      ST_PUSH
   } cpal_state_type;

   typedef struct packed {
      logic accept;
      logic diff;
      logic square;
      logic accum;
      logic root_step;
      logic len_update;
      logic push;
   } cpal_cmd_type;

   typedef struct packed {
      logic first_image;
      logic last_of_image;
      logic root_done;
      logic rsp_free;
   } cpal_status_type;

endpackage

@@ src/cpal_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpal_dpath
// Image store, squared difference accumulator, bit-pair square root and
// saturating running length with its result register.
// ----------------------------------------------------------------------------
module cpal_dpath #(
   parameter int MAX_COORDS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cpal_pkg::cpal_cmd_type   cmd,
   output cpal_pkg::cpal_status_type status,
   input  cpal_pkg::cpal_req_type   req_data,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output cpal_pkg::cpal_rsp_type   rsp_data
);
   import cpal_pkg::*;

   localparam int IDX_W = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_COORDS - 1);

   logic signed [COORD_W-1:0] image_mem [MAX_COORDS];

   cpal_req_type              item_ff;
   logic signed [COORD_W-1:0] prev_ff;
   logic [COORD_W-1:0]        abs_ff;
   logic [2*COORD_W-1:0]      sq_ff;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [SUM_W-1:0]          x_ff;
   logic [REM_W-1:0]          rem_ff;
   logic [ROOT_W-1:0]         root_ff;
   logic [STEP_W-1:0]         step_ff;
   logic [LEN_W-1:0]          len_ff, len_in;
   logic                      rsp_valid_ff;
   cpal_rsp_type              rsp_ff;

   logic signed [COORD_W:0]   diff;
   logic [COORD_W:0]          diff_mag;
   logic [SUM_W:0]            sum_add;
   logic [SUM_W-1:0]          sum_sat;
   logic [REM_W-1:0]          rem_shift;
   logic [REM_W-1:0]          trial;
   logic                      take;
   logic [LEN_W:0]            len_add;

   // image store
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         prev_ff <= image_mem[idx_ff];
      end
      if (cmd.accum) begin
         image_mem[idx_ff] <= item_ff.coord;
      end
   end

   always_comb begin
      diff     = {item_ff.coord[COORD_W-1], item_ff.coord} - {prev_ff[COORD_W-1], prev_ff};
      diff_mag = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;
      sum_add  = {1'b0, sum_ff} + (SUM_W+1)'(sq_ff);
      sum_sat  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
      sum_in   = item_ff.first_image ? sum_ff : sum_sat;
      idx_in   = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
      rem_shift = {rem_ff[REM_W-3:0], x_ff[SUM_W-1 -: 2]};
      trial     = {root_ff, 2'b01};
      take      = (rem_shift >= trial);
      len_add   = {1'b0, len_ff} + (LEN_W+1)'(root_ff);
      len_in    = len_add[LEN_W] ? {LEN_W{1'b1}} : len_add[LEN_W-1:0];
   end

   // payload pipeline
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff <= req_data;
      end
      if (cmd.diff) begin
         abs_ff <= diff_mag[COORD_W-1:0];
      end
      if (cmd.square) begin
         sq_ff <= abs_ff * abs_ff;
      end
      if (cmd.accum) begin
         x_ff    <= sum_in;
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= '0;
      end else if (cmd.root_step) begin
         x_ff    <= {x_ff[SUM_W-3:0], 2'b00};
         rem_ff  <= take ? rem_shift - trial : rem_shift;
         root_ff <= {root_ff[ROOT_W-2:0], take};
         step_ff <= step_ff + 1'b1;
      end
      if (cmd.push) begin
         rsp_ff.arc_length <= len_ff;
         rsp_ff.saturated  <= (len_ff == {LEN_W{1'b1}});
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         idx_ff       <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accum) begin
            if (item_ff.last_of_image) begin
               sum_ff <= '0;
               idx_ff <= '0;
            end else begin
               sum_ff <= sum_in;
               idx_ff <= idx_in;
            end
         end
         if (cmd.len_update) begin
            len_ff <= item_ff.first_image ? '0 : len_in;
         end
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.first_image   = item_ff.first_image;
   assign status.last_of_image = item_ff.last_of_image;
   assign status.root_done     = (step_ff == STEP_W'(ROOT_STEPS - 1));
   assign status.rsp_free      = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ src/cpal_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpal_ctrl
// Sequencer for one coordinate beat: read, difference, square, accumulate,
// and at the end of an image the root (skipped for the first image), length update and result push.
// ----------------------------------------------------------------------------
module cpal_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cpal_pkg::cpal_status_type status,
   output cpal_pkg::cpal_cmd_type    cmd
);
   import cpal_pkg::*;

   cpal_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_READ;
         end
         ST_READ:   state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_ACCUM;
         ST_ACCUM: begin
            if (!status.last_of_image) state_in = ST_IDLE;
            else if (status.first_image) state_in = ST_LENGTH;
            else state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (status.root_done) state_in = ST_LENGTH;
         end
         ST_LENGTH: state_in = ST_PUSH;
         ST_PUSH: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_READ:   cmd.diff       = 1'b1;
         ST_SQUARE: cmd.square     = 1'b1;
         ST_ACCUM:  cmd.accum      = 1'b1;
         ST_ROOT:   cmd.root_step  = 1'b1;
         ST_LENGTH: cmd.len_update = 1'b1;
         ST_PUSH:   cmd.push       = status.rsp_free;
         default:   cmd            = '0;
      endcase
   end

endmodule

@@ src/cumulative_path_arc_length_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cumulative_path_arc_length_top
// Running arc length over a path of images streamed one coordinate a beat.
//
//   channel  ports                          beat
//   req      req_valid req_stall req_data   coord, first_image, last_of_image
//   rsp      rsp_valid rsp_stall rsp_data   arc_length, saturated
//
// A coordinate passes through store read, difference, square and accumulate
// before the next is accepted. On the last coordinate of a non-first image
// the 30-step square root follows, and on the last coordinate of every image
// the length update and the result push, which waits for a free output. Reset
// is synchronous and clears the index, sum and length. A stalled result waits
// in its output register while the next coordinate is already taken.
// ----------------------------------------------------------------------------
module cumulative_path_arc_length_top #(
   parameter int MAX_COORDS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cpal_pkg::cpal_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cpal_pkg::cpal_rsp_type rsp_data
);
   import cpal_pkg::*;

   cpal_cmd_type    cmd;
   cpal_status_type status;

   cpal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cpal_dpath #(
      .MAX_COORDS (MAX_COORDS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
